[hdl/peer_table_with_aging_assert.svh]
// assertion macros shared by the peer table modules
`ifndef PEER_TABLE_WITH_AGING_ASSERT_SVH
`define PEER_TABLE_WITH_AGING_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define PTWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is held
`define PTWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ptwa_pkg.sv]
// types and constants of the peer table with aging
`timescale 1ns / 1ps

package ptwa_pkg;

  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int TMO_W  = 16;
  localparam int CNT_W  = 7;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd6000;
  localparam logic [CNT_W-1:0] COUNT_MAX     = 7'd127;

  localparam logic FUNC_HEARD = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // table word: {valid, id, time}
  localparam int WORD_W = 1 + ID_W + TIME_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture an input beat, clear per-item status
    logic clear_wr;  // write an invalid word at the sweep address
    logic rd_en;     // read the entry at the scan address
    logic eval;      // read data of the previous address is valid
    logic insert;    // place the heard id if it found no match and a free slot
    logic out_load;  // move the result into the output register
  } ctl_cmd_t;

endpackage

[hdl/ptwa_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ptwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/ptwa_ctrl.sv]
// sequencer of the peer table: clearing sweep, scan, insert, result
`timescale 1ns / 1ps

module ptwa_ctrl #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ptwa_pkg::ctl_cmd_t             cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0] addr
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  ptwa_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             eval_r, eval_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last;

  assign last = (idx_r == LAST_IDX);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptwa_pkg::ST_CLEAR:  if (last) state_nxt = ptwa_pkg::ST_IDLE;
      ptwa_pkg::ST_IDLE:   if (in_valid) state_nxt = ptwa_pkg::ST_SCAN;
      ptwa_pkg::ST_SCAN:   if (last) state_nxt = ptwa_pkg::ST_FLUSH;
      ptwa_pkg::ST_FLUSH:  state_nxt = ptwa_pkg::ST_INSERT;
      ptwa_pkg::ST_INSERT: state_nxt = ptwa_pkg::ST_DONE;
      ptwa_pkg::ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ptwa_pkg::ST_IDLE;
      default:             state_nxt = ptwa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    cmd.eval     = eval_r;
    unique case (state_r)
      ptwa_pkg::ST_CLEAR:  cmd.clear_wr = 1'b1;
      ptwa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ptwa_pkg::ST_SCAN:   cmd.rd_en = 1'b1;
      ptwa_pkg::ST_FLUSH:  ;
      ptwa_pkg::ST_INSERT: cmd.insert = 1'b1;
      ptwa_pkg::ST_DONE:   cmd.out_load = !out_valid_r || !out_stall;
      default:             ;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.clear_wr || cmd.rd_en) begin
      idx_nxt = last ? '0 : idx_r + AW'(1);
    end
  end

  assign eval_nxt = cmd.rd_en;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptwa_pkg::ST_CLEAR;
      idx_r       <= '0;
      eval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      eval_r      <= eval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign addr      = idx_r;
  assign out_valid = out_valid_r;

  `include "peer_table_with_aging_assert.svh"

  `PTWA_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !cmd.out_load, "result overwritten while stalled")
  `PTWA_ASSERT_NEXT(a_scan_start, clk, rst_n, cmd.load, (state_r == ptwa_pkg::ST_SCAN) && (idx_r == '0), "scan did not start at entry zero")
  `PTWA_ASSERT_NEXT(a_scan_end, clk, rst_n, (state_r == ptwa_pkg::ST_SCAN) && last, (state_r == ptwa_pkg::ST_FLUSH) && eval_r, "last entry not evaluated")

endmodule

[hdl/ptwa_dp.sv]
// datapath of the peer table: entry ram, match and age checks, counters
`timescale 1ns / 1ps

module ptwa_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptwa_pkg::ctl_cmd_t              cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  addr,
  input  logic                            cfg_we,
  input  logic [ptwa_pkg::TMO_W-1:0]      cfg_timeout_ms,
  input  logic                            in_func,
  input  logic [ptwa_pkg::TIME_W-1:0]     in_now_ms,
  input  logic [ptwa_pkg::ID_W-1:0]       in_peer_id,
  output logic [ptwa_pkg::CNT_W-1:0]      out_live_count,
  output logic                            out_refreshed,
  output logic                            out_inserted,
  output logic                            out_dropped
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int TW = ptwa_pkg::TIME_W;

  logic [ptwa_pkg::TMO_W-1:0]  timeout_r;
  logic                        func_r;
  logic [TW-1:0]               now_r;
  logic [ptwa_pkg::ID_W-1:0]   pid_r;
  logic [AW-1:0]               proc_idx_r;
  logic [AW-1:0]               free_idx_r;
  logic                        refreshed_r, free_found_r, inserted_r;
  logic [ptwa_pkg::CNT_W-1:0]  live_r;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [ptwa_pkg::WORD_W-1:0] wdata, rdata;

  logic                        rd_valid;
  logic [ptwa_pkg::ID_W-1:0]   rd_id;
  logic [TW-1:0]               rd_time;
  logic [TW:0]                 expiry;
  logic                        heard, hit, alive, is_free, tmo_nz, do_insert, count_inc;

  assign {rd_valid, rd_id, rd_time} = rdata;

  // expiry formed one bit wider so it never wraps
  assign expiry  = {1'b0, rd_time} + {{(TW + 1 - ptwa_pkg::TMO_W){1'b0}}, timeout_r};
  assign heard   = (func_r == ptwa_pkg::FUNC_HEARD);
  assign hit     = heard && rd_valid && (rd_id == pid_r);
  assign alive   = rd_valid && (expiry > {1'b0, now_r});
  assign is_free = !rd_valid || ({1'b0, now_r} > expiry);
  assign tmo_nz  = (timeout_r != '0);

  // a refreshed entry holds now, so it lives exactly when the timeout is nonzero
  assign count_inc = hit ? tmo_nz : alive;
  assign do_insert = cmd.insert && heard && !refreshed_r && free_found_r;

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.eval && hit) begin
      we    = 1'b1;
      waddr = proc_idx_r;
      wdata = {1'b1, rd_id, now_r};
    end else if (do_insert) begin
      we    = 1'b1;
      waddr = free_idx_r;
      wdata = {1'b1, pid_r, now_r};
    end
  end

  ptwa_ram #(
    .WIDTH (ptwa_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ptwa_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r       <= in_func;
      now_r        <= in_now_ms;
      pid_r        <= in_peer_id;
      refreshed_r  <= 1'b0;
      free_found_r <= 1'b0;
      inserted_r   <= 1'b0;
      live_r       <= '0;
    end else begin
      if (cmd.eval) begin
        if (hit) begin
          refreshed_r <= 1'b1;
        end
        if (heard && !free_found_r && is_free) begin
          free_found_r <= 1'b1;
          free_idx_r   <= proc_idx_r;
        end
        if (count_inc && (live_r < ptwa_pkg::COUNT_MAX)) begin
          live_r <= live_r + ptwa_pkg::CNT_W'(1);
        end
      end
      if (do_insert) begin
        inserted_r <= 1'b1;
        // the slot taken was not alive, so only the new entry can add
        if (tmo_nz && (live_r < ptwa_pkg::COUNT_MAX)) begin
          live_r <= live_r + ptwa_pkg::CNT_W'(1);
        end
      end
    end
    if (cmd.rd_en) begin
      proc_idx_r <= addr;
    end
    if (cmd.out_load) begin
      out_live_count <= live_r;
      out_refreshed  <= refreshed_r;
      out_inserted   <= inserted_r;
      out_dropped    <= heard && !refreshed_r && !inserted_r;
    end
  end

  `include "peer_table_with_aging_assert.svh"

  `PTWA_ASSERT_SAME(a_one_outcome, clk, rst_n, cmd.out_load, !(refreshed_r && inserted_r), "entry both refreshed and inserted")
  `PTWA_ASSERT_NEXT(a_tick_quiet, clk, rst_n, cmd.out_load && !heard, !out_refreshed && !out_inserted && !out_dropped, "tick reported a table change")

endmodule

[hdl/peer_table_with_aging.sv]
// top level of the peer table with timeout aging
// a result is loaded into the output register in the done state, after the scan, flush and insert states
// a new item is taken only in the idle state, once the last result is loaded; the ram scan reads one entry per cycle
// a heard peer costs the same as a tick: one scan, one optional insert write, one result load
// reset: synchronous rst_n clears control and sets timeout_ms to 6000, then a clearing
// sweep over all TABLE_DEPTH entries marks every entry invalid while in_stall stays high
`timescale 1ns / 1ps

module peer_table_with_aging #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel, timeout in milliseconds
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptwa_pkg::TMO_W-1:0]     cfg_timeout_ms,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [ptwa_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [ptwa_pkg::ID_W-1:0]      in_peer_id,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ptwa_pkg::CNT_W-1:0]     out_live_count,
  output logic                           out_refreshed,
  output logic                           out_inserted,
  output logic                           out_dropped
);

  localparam int AW = $clog2(TABLE_DEPTH);

  ptwa_pkg::ctl_cmd_t cmd;
  logic [AW-1:0]      addr;

  // the timeout register takes a beat in any cycle; writes are to come only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  // sequencer: sweep after reset, then per item scan -> flush -> insert -> done
  ptwa_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .addr      (addr)
  );

  // entry ram with {valid, id, time} words, match, age and live-count logic
  ptwa_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .addr           (addr),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_timeout_ms (cfg_timeout_ms),
    .in_func        (in_func),
    .in_now_ms      (in_now_ms),
    .in_peer_id     (in_peer_id),
    .out_live_count (out_live_count),
    .out_refreshed  (out_refreshed),
    .out_inserted   (out_inserted),
    .out_dropped    (out_dropped)
  );

endmodule

[bench/ptwa_census_check.sv]
// checker of the peer table: mirrors the table, predicts each result beat and compares it
`timescale 1ns / 1ps

module ptwa_census_check #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ptwa_pkg::TMO_W-1:0]    cfg_timeout_ms,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_func,
  input  logic [ptwa_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [ptwa_pkg::ID_W-1:0]     in_peer_id,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ptwa_pkg::CNT_W-1:0]    out_live_count,
  input  logic                          out_refreshed,
  input  logic                          out_inserted,
  input  logic                          out_dropped,
  output int                            mismatches,
  output int                            awaiting
);

  typedef struct {
    logic [ptwa_pkg::CNT_W-1:0] live_count;
    logic                       refreshed;
    logic                       inserted;
    logic                       dropped;
  } census_t;

  logic [ptwa_pkg::ID_W-1:0]   slot_id    [TABLE_DEPTH];
  logic [ptwa_pkg::TIME_W-1:0] slot_time  [TABLE_DEPTH];
  logic                        slot_valid [TABLE_DEPTH];
  logic [ptwa_pkg::TMO_W-1:0]  window_ms;
  census_t                     census_q [$];

  // expiry time at 33 bits, so it never wraps
  function automatic logic [ptwa_pkg::TIME_W:0] deadline_of(int i);
    return {1'b0, slot_time[i]} +
           {{(ptwa_pkg::TIME_W + 1 - ptwa_pkg::TMO_W){1'b0}}, window_ms};
  endfunction

  task automatic apply_beat(input logic func, input logic [ptwa_pkg::TIME_W-1:0] now,
                            input logic [ptwa_pkg::ID_W-1:0] pid);
    census_t c;
    int      live;
    c.refreshed = 1'b0;
    c.inserted  = 1'b0;
    if (func == ptwa_pkg::FUNC_HEARD) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_valid[i] && slot_id[i] == pid) begin
          slot_time[i] = now;
          c.refreshed  = 1'b1;
        end
      end
      // lowest free or expired slot takes the new peer
      if (!c.refreshed) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!c.inserted && (!slot_valid[i] || {1'b0, now} > deadline_of(i))) begin
            slot_id[i]    = pid;
            slot_time[i]  = now;
            slot_valid[i] = 1'b1;
            c.inserted    = 1'b1;
          end
        end
      end
    end
    c.dropped = (func == ptwa_pkg::FUNC_HEARD) && !c.refreshed && !c.inserted;
    live = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_valid[i] && deadline_of(i) > {1'b0, now} &&
          live < int'(ptwa_pkg::COUNT_MAX))
        live++;
    end
    c.live_count = live[ptwa_pkg::CNT_W-1:0];
    census_q.push_back(c);
  endtask

  task automatic check_field(input string field, input logic [ptwa_pkg::CNT_W-1:0] want,
                             input logic [ptwa_pkg::CNT_W-1:0] got, inout int bad);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    int      bad;
    census_t want;
    bad = 0;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_valid[i] = 1'b0;
      window_ms = ptwa_pkg::TIMEOUT_RESET;
      census_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) window_ms = cfg_timeout_ms;
      if (out_valid && !out_stall) begin
        if (census_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, live_count %0d",
                   $time, out_live_count);
          bad++;
        end else begin
          want = census_q.pop_front();
          check_field("live_count", want.live_count, out_live_count, bad);
          check_field("refreshed", ptwa_pkg::CNT_W'(want.refreshed),
                      ptwa_pkg::CNT_W'(out_refreshed), bad);
          check_field("inserted", ptwa_pkg::CNT_W'(want.inserted),
                      ptwa_pkg::CNT_W'(out_inserted), bad);
          check_field("dropped", ptwa_pkg::CNT_W'(want.dropped),
                      ptwa_pkg::CNT_W'(out_dropped), bad);
        end
      end
      if (in_valid && !in_stall) apply_beat(in_func, in_now_ms, in_peer_id);
      mismatches <= mismatches + bad;
    end
    awaiting <= census_q.size();
  end

endmodule

[bench/tb_peer_table_with_aging.sv]
// testbench top of the peer table with aging: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_peer_table_with_aging;

  localparam int DEPTH       = 64;
  localparam int POOL        = 80;
  localparam int PHASES      = 8;
  // watchdog limit, this leaves a wide margin over the slowest run
  localparam int CYCLE_LIMIT = 400000;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        cfg_valid      = 1'b0;
  logic                        cfg_ready;
  logic [ptwa_pkg::TMO_W-1:0]  cfg_timeout_ms = '0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic                        in_func        = ptwa_pkg::FUNC_TICK;
  logic [ptwa_pkg::TIME_W-1:0] in_now_ms      = '0;
  logic [ptwa_pkg::ID_W-1:0]   in_peer_id     = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic [ptwa_pkg::CNT_W-1:0]  out_live_count;
  logic                        out_refreshed;
  logic                        out_inserted;
  logic                        out_dropped;

  int                          mismatches;
  int                          awaiting;

  // percent of cycles in which the sender idles or the receiver stalls
  int                          idle_pct  = 0;
  int                          stall_pct = 0;
  // timeout currently programmed, steers the time steps of the random part
  logic [ptwa_pkg::TMO_W-1:0]  tmo       = ptwa_pkg::TIMEOUT_RESET;
  int unsigned                 cycles    = 0;

  always #6 clk = ~clk;

  peer_table_with_aging #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_timeout_ms (cfg_timeout_ms),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_now_ms      (in_now_ms),
    .in_peer_id     (in_peer_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_live_count (out_live_count),
    .out_refreshed  (out_refreshed),
    .out_inserted   (out_inserted),
    .out_dropped    (out_dropped)
  );

  ptwa_census_check #(
    .TABLE_DEPTH(DEPTH)
  ) u_census_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_timeout_ms (cfg_timeout_ms),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_now_ms      (in_now_ms),
    .in_peer_id     (in_peer_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_live_count (out_live_count),
    .out_refreshed  (out_refreshed),
    .out_inserted   (out_inserted),
    .out_dropped    (out_dropped),
    .mismatches     (mismatches),
    .awaiting       (awaiting)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // present one beat and hold it until accepted; valid stays high afterwards
  // so back-to-back beats never lower and raise it in the same step
  task automatic offer_beat(input logic func, input logic [ptwa_pkg::TIME_W-1:0] now,
                            input logic [ptwa_pkg::ID_W-1:0] pid);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_now_ms  <= now;
    in_peer_id <= pid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every predicted result beat has come back
  task automatic await_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // timeout writes only happen with the block drained
  task automatic set_timeout(input logic [ptwa_pkg::TMO_W-1:0] value);
    await_quiet();
    cfg_valid      <= 1'b1;
    cfg_timeout_ms <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tmo = value;
  endtask

  initial begin
    logic [ptwa_pkg::TIME_W-1:0] now;
    logic [ptwa_pkg::ID_W-1:0]   pid;
    logic                        func;
    int unsigned                 t;
    int                          r;
    int                          fresh_pct;
    logic [ptwa_pkg::ID_W-1:0]   peer_pool    [POOL];
    logic [ptwa_pkg::ID_W-1:0]   recent_ids   [8];
    logic [ptwa_pkg::TIME_W-1:0] recent_times [8];
    logic [ptwa_pkg::TMO_W-1:0]  phase_tmo    [PHASES];
    int                          phase_items  [PHASES];

    for (int i = 0; i < POOL; i++) peer_pool[i] = $urandom;
    for (int i = 0; i < 8; i++) begin
      recent_ids[i]   = peer_pool[i];
      recent_times[i] = '0;
    end
    // extremes of the timeout plus a spread of ordinary values
    phase_tmo   = '{16'hFFFF, 16'd1, 16'd0, 16'd6000, 16'd250, 16'd0, 16'd40000, 16'd30};
    phase_tmo[5] = ptwa_pkg::TMO_W'($urandom_range(2, 65534));
    phase_items = '{120, 60, 60, 60, 70, 60, 60, 60};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part with the reset timeout of 6000 ms
    offer_beat(ptwa_pkg::FUNC_TICK, 32'd0, 32'hFFFF_FFFF);          // empty table counts zero
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd0, 32'h0000_0000);         // lowest id into slot 0
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd0, 32'hFFFF_FFFF);         // highest id into slot 1
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd100, 32'h0000_0000);       // refresh of slot 0
    offer_beat(ptwa_pkg::FUNC_TICK, 32'd6000, 32'h0);  // slot 1 sits exactly on its deadline
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd6000, 32'h1234_5678);  // boundary slot not free
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd6001, 32'h8765_4321);  // one past deadline, reused
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd6001, 32'hFFFF_FFFF);  // evicted id comes back
    offer_beat(ptwa_pkg::FUNC_TICK, 32'hFFFF_FFFF, 32'h5A5A_5A5A);  // everything aged out
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'hFFFF_FFFF, 32'hA5A5_A5A5); // deadline beyond 32 bits
    offer_beat(ptwa_pkg::FUNC_TICK, 32'hFFFF_FFFF, 32'h0);
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd5, 32'hA5A5_A5A5);         // clock steps back, refresh
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd3, 32'h0000_0001);         // back again, insert
    offer_beat(ptwa_pkg::FUNC_TICK, 32'h7FFF_FFFF, 32'h0);

    // zero timeout: only entries stamped in the future stay alive
    set_timeout(16'd0);
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd10, 32'h0000_0002);
    offer_beat(ptwa_pkg::FUNC_TICK, 32'd9, 32'h0);
    offer_beat(ptwa_pkg::FUNC_TICK, 32'd10, 32'h0);
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd10, 32'h0000_0003);        // equal time, slot not free
    offer_beat(ptwa_pkg::FUNC_HEARD, 32'd11, 32'h0000_0004);

    now = 32'd20;
    for (int p = 0; p < PHASES; p++) begin
      set_timeout(phase_tmo[p]);
      t = 32'(tmo);
      // idling mode cycles through: none, sender idle, receiver stall, both
      unique case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      // some phases jump the clock, near the top of the range or anywhere
      if (p == 3) now = 32'hFFFF_F000;
      else if (p == 5) now = $urandom;
      // the first phase floods the table with new peers so it fills up and drops
      fresh_pct = (p == 0) ? 70 : 10;

      for (int k = 0; k < phase_items[p]; k++) begin
        r = $urandom_range(0, 99);
        if (p == 0)
          now = now + $urandom_range(0, 200);
        else if (r < 45)
          now = now + $urandom_range(0, t / 16 + 1);
        else if (r < 65)
          now = now + $urandom_range(0, t + 2);
        else if (r < 75)
          now = now;
        else if (r < 85)
          now = recent_times[$urandom_range(0, 7)] + t;    // land right on a deadline
        else if (r < 93)
          now = now + $urandom_range(t, 4 * t + 10);       // age out a batch
        else
          now = now - $urandom_range(0, t + 5);            // clock running backwards

        func = ($urandom_range(0, 99) < 20) ? ptwa_pkg::FUNC_TICK : ptwa_pkg::FUNC_HEARD;
        r = $urandom_range(0, 99);
        if (r < fresh_pct)
          pid = $urandom;
        else if (r < fresh_pct + 15)
          pid = recent_ids[$urandom_range(0, 7)];
        else if (r < fresh_pct + 20)
          pid = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        else
          pid = peer_pool[$urandom_range(0, POOL - 1)];

        offer_beat(func, now, pid);
        if (func == ptwa_pkg::FUNC_HEARD) begin
          recent_ids[k % 8]   = pid;
          recent_times[k % 8] = now;
        end
      end
    end

    await_quiet();
    // room for a stray extra beat to show up
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
